FILE: design/dbr_pkg.sv
// ----------------------------------------------------------------------------
// dbr_pkg: shared types and constants of the drunken-bishop picture block
// Default grid geometry, glyph codes and the output tag struct that the
// controller hands to the glyph stage.
// ----------------------------------------------------------------------------
package dbr_pkg;

  // default geometry
  localparam int GRID_ROWS_DEF    = 9;
  localparam int GRID_COLS_DEF    = 17;
  localparam int GLYPH_LEVELS_DEF = 15;

  // cell counter
  localparam int         CNT_W     = 4;
  localparam logic [3:0] COUNT_MAX = 4'd15;

  // glyph codes
  localparam logic [4:0] START_CODE = 5'd15;
  localparam logic [4:0] END_CODE   = 5'd16;

  // action codes
  localparam logic ACT_FEED = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // per-cell tag that travels beside the registered counter read
  typedef struct packed {
    logic       valid;
    logic [4:0] col;
    logic       last;
    logic       in_range;
    logic       is_end;
    logic       is_start;
  } cell_tag_t;

endpackage

FILE: design/dbr_cell_mem.sv
// ----------------------------------------------------------------------------
// dbr_cell_mem: cell counter store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dbr_cell_mem #(
  parameter int DEPTH  = dbr_pkg::GRID_ROWS_DEF * dbr_pkg::GRID_COLS_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [ADDR_W-1:0]        wr_addr,
  input  logic [dbr_pkg::CNT_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]        rd_addr,
  output logic [dbr_pkg::CNT_W-1:0] rd_data
);

  logic [dbr_pkg::CNT_W-1:0] mem [DEPTH];
  logic [dbr_pkg::CNT_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/dbr_ctrl.sv
// ----------------------------------------------------------------------------
// dbr_ctrl: sequencer of the drunken-bishop picture block
// Runs the clearing sweep, the read-modify-write bishop moves and the row
// scan over the single counter store; holds the bishop position.
// ----------------------------------------------------------------------------
module dbr_ctrl #(
  parameter int GRID_ROWS = dbr_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS = dbr_pkg::GRID_COLS_DEF,
  parameter int DEPTH     = GRID_ROWS * GRID_COLS,
  parameter int ADDR_W    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_action,
  input  logic [7:0]                in_data_byte,
  input  logic                      in_start_new,
  input  logic [3:0]                in_row_select,
  output logic                      mem_we,
  output logic [ADDR_W-1:0]         mem_wr_addr,
  output logic [dbr_pkg::CNT_W-1:0] mem_wr_data,
  output logic [ADDR_W-1:0]         mem_rd_addr,
  input  logic [dbr_pkg::CNT_W-1:0] mem_rd_data,
  output dbr_pkg::cell_tag_t        tag
);

  localparam int ROW_W = $clog2(GRID_ROWS);
  localparam int COL_W = $clog2(GRID_COLS);
  localparam logic [ROW_W-1:0]  ROW_C    = ROW_W'(GRID_ROWS / 2);
  localparam logic [COL_W-1:0]  COL_C    = COL_W'(GRID_COLS / 2);
  localparam logic [ROW_W-1:0]  ROW_MAX  = ROW_W'(GRID_ROWS - 1);
  localparam logic [COL_W-1:0]  COL_MAX  = COL_W'(GRID_COLS - 1);
  localparam logic [ADDR_W-1:0] ADDR_MAX = ADDR_W'(DEPTH - 1);
  localparam logic [ADDR_W-1:0] COLS_A   = ADDR_W'(GRID_COLS);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOVE,
    S_WRITE,
    S_ROW
  } state_t;

  state_t             state_r,    state_nxt;
  logic [ADDR_W-1:0]  addr_r,     addr_nxt;
  logic [ROW_W-1:0]   brow_r,     brow_nxt;
  logic [COL_W-1:0]   bcol_r,     bcol_nxt;
  logic [7:0]         bits_r,     bits_nxt;
  logic [1:0]         pair_r,     pair_nxt;
  logic               pend_r,     pend_nxt;
  logic [COL_W-1:0]   k_r,        k_nxt;
  logic [ROW_W-1:0]   row_r,      row_nxt;
  logic               inrng_r,    inrng_nxt;
  dbr_pkg::cell_tag_t tag_r,      tag_nxt;

  logic [ROW_W-1:0]   new_row;
  logic [COL_W-1:0]   new_col;
  logic [ADDR_W-1:0]  new_addr;
  logic               sel_ok;

  // clamped diagonal step from the low bit pair
  always_comb begin
    new_col = bcol_r;
    new_row = brow_r;
    if (bits_r[0]) begin
      if (bcol_r < COL_MAX) new_col = bcol_r + COL_W'(1);
    end else begin
      if (bcol_r != '0) new_col = bcol_r - COL_W'(1);
    end
    if (bits_r[1]) begin
      if (brow_r < ROW_MAX) new_row = brow_r + ROW_W'(1);
    end else begin
      if (brow_r != '0) new_row = brow_r - ROW_W'(1);
    end
    new_addr = ADDR_W'(new_row) * COLS_A + ADDR_W'(new_col);
  end

  assign sel_ok = ({1'b0, in_row_select} < 5'(GRID_ROWS));

  // sequencer next state
  always_comb begin
    state_nxt   = state_r;
    addr_nxt    = addr_r;
    brow_nxt    = brow_r;
    bcol_nxt    = bcol_r;
    bits_nxt    = bits_r;
    pair_nxt    = pair_r;
    pend_nxt    = pend_r;
    k_nxt       = k_r;
    row_nxt     = row_r;
    inrng_nxt   = inrng_r;
    tag_nxt     = '0;
    mem_we      = 1'b0;
    mem_wr_addr = addr_r;
    mem_wr_data = '0;
    mem_rd_addr = addr_r;
    unique case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (addr_r == ADDR_MAX) begin
          addr_nxt  = '0;
          pend_nxt  = 1'b0;
          state_nxt = pend_r ? S_MOVE : S_IDLE;
        end else begin
          addr_nxt = addr_r + ADDR_W'(1);
        end
      end
      S_IDLE: begin
        if (start) begin
          if (in_action == dbr_pkg::ACT_READ) begin
            k_nxt     = '0;
            inrng_nxt = sel_ok;
            row_nxt   = sel_ok ? in_row_select[ROW_W-1:0] : '0;
            addr_nxt  = sel_ok ? ADDR_W'(in_row_select[ROW_W-1:0]) * COLS_A : '0;
            state_nxt = S_ROW;
          end else begin
            bits_nxt = in_data_byte;
            pair_nxt = '0;
            if (in_start_new) begin
              brow_nxt  = ROW_C;
              bcol_nxt  = COL_C;
              addr_nxt  = '0;
              pend_nxt  = 1'b1;
              state_nxt = S_CLEAR;
            end else begin
              state_nxt = S_MOVE;
            end
          end
        end
      end
      S_MOVE: begin
        mem_rd_addr = new_addr;
        brow_nxt    = new_row;
        bcol_nxt    = new_col;
        addr_nxt    = new_addr;
        state_nxt   = S_WRITE;
      end
      S_WRITE: begin
        mem_we      = 1'b1;
        mem_wr_data = (mem_rd_data == dbr_pkg::COUNT_MAX) ? mem_rd_data
                                                          : mem_rd_data + 4'd1;
        bits_nxt    = {2'b00, bits_r[7:2]};
        pair_nxt    = pair_r + 2'd1;
        state_nxt   = (pair_r == 2'd3) ? S_IDLE : S_MOVE;
      end
      S_ROW: begin
        tag_nxt.valid    = 1'b1;
        tag_nxt.col      = 5'(k_r);
        tag_nxt.last     = (k_r == COL_MAX);
        tag_nxt.in_range = inrng_r;
        tag_nxt.is_end   = (row_r == brow_r) && (k_r == bcol_r);
        tag_nxt.is_start = (row_r == ROW_C) && (k_r == COL_C);
        if (k_r == COL_MAX) begin
          addr_nxt  = '0;
          state_nxt = S_IDLE;
        end else begin
          k_nxt = k_r + COL_W'(1);
          if (inrng_r) addr_nxt = addr_r + ADDR_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      addr_r  <= '0;
      brow_r  <= ROW_C;
      bcol_r  <= COL_C;
      pair_r  <= '0;
      pend_r  <= 1'b0;
      k_r     <= '0;
      inrng_r <= 1'b0;
      tag_r   <= '0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
      brow_r  <= brow_nxt;
      bcol_r  <= bcol_nxt;
      pair_r  <= pair_nxt;
      pend_r  <= pend_nxt;
      k_r     <= k_nxt;
      inrng_r <= inrng_nxt;
      tag_r   <= tag_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    bits_r <= bits_nxt;
    row_r  <= row_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign tag  = tag_r;

`ifndef SYNTHESIS
  // a cell beat only follows a row scan cycle
  a_tag_from_row: assert property (@(posedge clk) disable iff (!rst_n)
    tag_r.valid |-> $past(state_r == S_ROW))
    else $error("cell beat without row scan");

  // the row scan never writes the store
  a_no_write_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROW) |-> !mem_we)
    else $error("store written during row scan");

  // bishop stays on the grid
  a_bishop_on_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (brow_r <= ROW_MAX) && (bcol_r <= COL_MAX))
    else $error("bishop off grid");

  // an accepted item always keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item left block idle");
`endif

endmodule

FILE: design/drunken_bishop_randomart.sv
// ----------------------------------------------------------------------------
// drunken_bishop_randomart: drunken-bishop fingerprint picture engine
// Feeds fingerprint bytes into a grid of saturating cell counters and reads
// the picture back one row at a time as glyph codes.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. A feed byte makes
// four moves: each reads the counter store in its move state and then writes
// the incremented count in its write state, over the store's one read port
// and one write port. A feed with in_start_new set first sweeps all
// GRID_ROWS*GRID_COLS cells of the store to zero. After reset the same
// clearing sweep runs, and busy stays high until it ends. A row read
// keeps busy high during its row scan; its GRID_COLS cells come out one per
// cycle on out_valid, each with a registered cell tag beside the registered
// counter read, with out_last on the final column. The receiver cannot stall:
// every out_valid beat is taken in the cycle it is shown.
// ----------------------------------------------------------------------------
module drunken_bishop_randomart #(
  parameter int GRID_ROWS    = dbr_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS    = dbr_pkg::GRID_COLS_DEF,
  parameter int GLYPH_LEVELS = dbr_pkg::GLYPH_LEVELS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_action,
  input  logic [7:0] in_data_byte,
  input  logic       in_start_new,
  input  logic [3:0] in_row_select,
  output logic       out_valid,
  output logic [4:0] out_glyph_code,
  output logic [4:0] out_column,
  output logic       out_last
);

  localparam int DEPTH  = GRID_ROWS * GRID_COLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [dbr_pkg::CNT_W-1:0] GLYPH_CAP = dbr_pkg::CNT_W'(GLYPH_LEVELS - 1);

  logic                      mem_we;
  logic [ADDR_W-1:0]         mem_wr_addr;
  logic [dbr_pkg::CNT_W-1:0] mem_wr_data;
  logic [ADDR_W-1:0]         mem_rd_addr;
  logic [dbr_pkg::CNT_W-1:0] mem_rd_data;
  dbr_pkg::cell_tag_t        tag;

  dbr_cell_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  dbr_ctrl #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS),
    .DEPTH     (DEPTH),
    .ADDR_W    (ADDR_W)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_action     (in_action),
    .in_data_byte  (in_data_byte),
    .in_start_new  (in_start_new),
    .in_row_select (in_row_select),
    .mem_we        (mem_we),
    .mem_wr_addr   (mem_wr_addr),
    .mem_wr_data   (mem_wr_data),
    .mem_rd_addr   (mem_rd_addr),
    .mem_rd_data   (mem_rd_data),
    .tag           (tag)
  );

  // glyph selection: zero outside the grid, then end marker over start marker over capped count
  always_comb begin
    priority if (!tag.in_range) begin
      out_glyph_code = '0;
    end else if (tag.is_end) begin
      out_glyph_code = dbr_pkg::END_CODE;
    end else if (tag.is_start) begin
      out_glyph_code = dbr_pkg::START_CODE;
    end else if (mem_rd_data > GLYPH_CAP) begin
      out_glyph_code = 5'(GLYPH_CAP);
    end else begin
      out_glyph_code = 5'(mem_rd_data);
    end
  end

  assign out_valid  = tag.valid;
  assign out_column = tag.col;
  assign out_last   = tag.last;

endmodule

FILE: tb/sv/tb_drunken_bishop_randomart.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_drunken_bishop_randomart: self-checking bench for the bishop picture engine
// A short table of hand-picked feeds and row reads goes first: blank grid,
// rows past the grid, edge clamping, counter saturation and marker
// precedence. Random fingerprints and stray commands follow. Every cell beat
// is checked against a behavioral copy of the walk and glyph rules or a known row.
// ----------------------------------------------------------------------------
module tb_drunken_bishop_randomart;

  localparam int ROWS        = dbr_pkg::GRID_ROWS_DEF;
  localparam int COLS        = dbr_pkg::GRID_COLS_DEF;
  localparam int LEVEL_CAP   = dbr_pkg::GLYPH_LEVELS_DEF - 1;
  localparam int ITEM_TARGET = 320;
  localparam logic [5:0] NO_MARK = 6'd63;

  // diagonal step codes, one per bit pair of a fingerprint byte
  typedef enum logic [1:0] {
    STEP_UP_LEFT, STEP_UP_RIGHT, STEP_DOWN_LEFT, STEP_DOWN_RIGHT
  } step_dir_t;

  typedef struct packed {
    logic [4:0] glyph;
    logic [4:0] col;
    logic       last;
  } cell_beat_t;

  // one command; known rows carry a blank row with at most one marker
  typedef struct packed {
    logic       action;
    logic [7:0] fp_byte;
    logic       start_new;
    logic [3:0] row;
    logic       known;
    logic [5:0] mark_col;
    logic [4:0] mark_glyph;
  } cmd_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic       in_action = dbr_pkg::ACT_FEED;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_start_new = 1'b0;
  logic [3:0] in_row_select = 4'd0;
  logic       out_valid;
  logic [4:0] out_glyph_code;
  logic [4:0] out_column;
  logic       out_last;

  // shadow of the picture
  logic [3:0] visit_count [ROWS][COLS];
  logic [3:0] bishop_r;
  logic [4:0] bishop_c;

  cell_beat_t pending_cells [$];
  cmd_t       directed [$];
  int         mismatches    = 0;
  int         cells_checked = 0;
  int         byte_feeds    = 0;
  int         row_reads     = 0;

  always #10 clk = ~clk;

  drunken_bishop_randomart uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_action     (in_action),
    .in_data_byte  (in_data_byte),
    .in_start_new  (in_start_new),
    .in_row_select (in_row_select),
    .out_valid     (out_valid),
    .out_glyph_code(out_glyph_code),
    .out_column    (out_column),
    .out_last      (out_last)
  );

  // wipe the counters and put the bishop back on the centre
  task automatic clear_art();
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) visit_count[r][c] = '0;
    end
    bishop_r = 4'(ROWS / 2);
    bishop_c = 5'(COLS / 2);
  endtask

  // walk a fed byte, or queue the glyphs of a read row
  task automatic walk_or_render(input cmd_t cmd);
    step_dir_t  dir;
    logic [4:0] glyph;
    if (cmd.action == dbr_pkg::ACT_FEED) begin
      if (cmd.start_new) clear_art();
      for (int k = 0; k < 4; k++) begin
        dir = step_dir_t'(cmd.fp_byte[2*k +: 2]);
        if (dir == STEP_UP_RIGHT || dir == STEP_DOWN_RIGHT) begin
          if (bishop_c < COLS - 1) bishop_c++;
        end else if (bishop_c > 0) begin
          bishop_c--;
        end
        if (dir == STEP_DOWN_LEFT || dir == STEP_DOWN_RIGHT) begin
          if (bishop_r < ROWS - 1) bishop_r++;
        end else if (bishop_r > 0) begin
          bishop_r--;
        end
        // counters saturate
        if (visit_count[bishop_r][bishop_c] != dbr_pkg::COUNT_MAX)
          visit_count[bishop_r][bishop_c]++;
      end
    end else begin
      for (int k = 0; k < COLS; k++) begin
        if (cmd.row >= ROWS) glyph = '0;
        else if (cmd.row == bishop_r && k == bishop_c) glyph = dbr_pkg::END_CODE;
        else if (cmd.row == ROWS / 2 && k == COLS / 2) glyph = dbr_pkg::START_CODE;
        else if (visit_count[cmd.row][k] > LEVEL_CAP) glyph = 5'(LEVEL_CAP);
        else glyph = 5'(visit_count[cmd.row][k]);
        pending_cells.push_back({glyph, 5'(k), k == COLS - 1});
      end
    end
  endtask

  task automatic plan(input logic action, input logic [7:0] fp_byte, input logic start_new,
                      input logic [3:0] row, input logic known, input logic [5:0] mark_col,
                      input logic [4:0] mark_glyph);
    cmd_t cmd;
    cmd = '0;
    cmd.action     = action;
    cmd.fp_byte    = fp_byte;
    cmd.start_new  = start_new;
    cmd.row        = row;
    cmd.known      = known;
    cmd.mark_col   = mark_col;
    cmd.mark_glyph = mark_glyph;
    directed.push_back(cmd);
  endtask

  // mostly no gap, some short, a few long
  function automatic int pick_gap(input bit no_idle);
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // hold the command until the block takes it, then record what it implies
  task automatic issue(input cmd_t cmd, input int gap);
    start         <= 1'b1;
    in_action     <= cmd.action;
    in_data_byte  <= cmd.fp_byte;
    in_start_new  <= cmd.start_new;
    in_row_select <= cmd.row;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (cmd.action == dbr_pkg::ACT_READ) row_reads++;
    else byte_feeds++;
    if (cmd.known) begin
      for (int k = 0; k < COLS; k++)
        pending_cells.push_back({(k == cmd.mark_col) ? cmd.mark_glyph : 5'd0, 5'(k),
                                 k == COLS - 1});
    end else begin
      walk_or_render(cmd);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // compare each cell beat with the oldest expectation
  always @(posedge clk) begin : cell_check
    cell_beat_t want;
    if (rst_n && out_valid) begin
      if (pending_cells.size() == 0) begin
        $error("unexpected cell beat: column %0d glyph_code %0d", out_column, out_glyph_code);
        mismatches++;
      end else begin
        want = pending_cells.pop_front();
        cells_checked++;
        if (out_glyph_code !== want.glyph) begin
          $error("glyph_code: expected %0d, got %0d (column %0d)",
                 want.glyph, out_glyph_code, want.col);
          mismatches++;
        end
        if (out_column !== want.col) begin
          $error("column: expected %0d, got %0d", want.col, out_column);
          mismatches++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d, got %0d (column %0d)", want.last, out_last, want.col);
          mismatches++;
        end
      end
    end
  end

  initial begin
    cmd_t cmd;
    bit   no_idle;
    int   n_bytes;
    int   n_cmds;

    // blank grid after reset, rows past the grid, ignored fields on a read
    plan(dbr_pkg::ACT_READ, 8'h00, 1'b0, 4'(ROWS / 2), 1'b1, 6'(COLS / 2),
         dbr_pkg::END_CODE);
    plan(dbr_pkg::ACT_READ, 8'h00, 1'b0, 4'd0, 1'b1, NO_MARK, 5'd0);
    plan(dbr_pkg::ACT_READ, 8'hFF, 1'b1, 4'(ROWS - 1), 1'b1, NO_MARK, 5'd0);
    plan(dbr_pkg::ACT_READ, 8'h5A, 1'b1, 4'(ROWS), 1'b1, NO_MARK, 5'd0);
    plan(dbr_pkg::ACT_READ, 8'hA5, 1'b0, 4'd15, 1'b1, NO_MARK, 5'd0);
    // four up-left steps to the top edge; row field ignored on a feed
    plan(dbr_pkg::ACT_FEED, 8'h00, 1'b1, 4'd15, 1'b0, NO_MARK, 5'd0);
    plan(dbr_pkg::ACT_READ, 8'hFF, 1'b1, 4'd0, 1'b1, 6'(COLS / 2 - 4), dbr_pkg::END_CODE);
    plan(dbr_pkg::ACT_READ, 8'h00, 1'b0, 4'(ROWS / 2), 1'b1, 6'(COLS / 2),
         dbr_pkg::START_CODE);
    // back onto the centre: end marker wins over start marker
    plan(dbr_pkg::ACT_FEED, 8'hFF, 1'b0, 4'd0, 1'b0, NO_MARK, 5'd0);
    plan(dbr_pkg::ACT_READ, 8'h00, 1'b0, 4'(ROWS / 2), 1'b0, NO_MARK, 5'd0);
    plan(dbr_pkg::ACT_READ, 8'h00, 1'b0, 4'd2, 1'b0, NO_MARK, 5'd0);
    // pin the bishop in the top-left corner until its counter saturates
    repeat (6) plan(dbr_pkg::ACT_FEED, 8'h00, 1'b0, 4'd0, 1'b0, NO_MARK, 5'd0);
    plan(dbr_pkg::ACT_READ, 8'h00, 1'b0, 4'd0, 1'b0, NO_MARK, 5'd0);
    // remaining step directions, then the bottom-right corner
    plan(dbr_pkg::ACT_FEED, 8'h55, 1'b1, 4'd3, 1'b0, NO_MARK, 5'd0);
    plan(dbr_pkg::ACT_FEED, 8'hAA, 1'b0, 4'd7, 1'b0, NO_MARK, 5'd0);
    plan(dbr_pkg::ACT_FEED, 8'h1B, 1'b0, 4'd0, 1'b0, NO_MARK, 5'd0);
    repeat (3) plan(dbr_pkg::ACT_FEED, 8'hFF, 1'b0, 4'd0, 1'b0, NO_MARK, 5'd0);
    plan(dbr_pkg::ACT_READ, 8'h00, 1'b0, 4'(ROWS - 1), 1'b0, NO_MARK, 5'd0);

    clear_art();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (directed[i]) issue(directed[i], pick_gap(i < 8));

    // random fingerprints with row reads, mixed with stray commands
    while (byte_feeds + row_reads < ITEM_TARGET) begin
      no_idle = ($urandom_range(0, 3) == 0);
      cmd = '0;
      if ($urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 5))
          0:       n_bytes = 16;
          1:       n_bytes = 32;
          2:       n_bytes = $urandom_range(40, 64);
          default: n_bytes = $urandom_range(1, 12);
        endcase
        for (int b = 0; b < n_bytes; b++) begin
          cmd.action    = dbr_pkg::ACT_FEED;
          cmd.fp_byte   = 8'($urandom);
          cmd.start_new = (b == 0);
          cmd.row       = 4'($urandom);
          issue(cmd, pick_gap(no_idle));
        end
        n_cmds = $urandom_range(0, 1) ? ROWS : $urandom_range(1, 4);
        for (int r = 0; r < n_cmds; r++) begin
          cmd.action    = dbr_pkg::ACT_READ;
          cmd.fp_byte   = 8'($urandom);
          cmd.start_new = 1'($urandom);
          cmd.row       = (n_cmds == ROWS) ? 4'(r) : 4'($urandom_range(0, ROWS - 1));
          issue(cmd, pick_gap(no_idle));
        end
      end else begin
        n_cmds = $urandom_range(1, 6);
        repeat (n_cmds) begin
          cmd.action    = 1'($urandom);
          cmd.fp_byte   = 8'($urandom);
          cmd.start_new = ($urandom_range(0, 5) == 0);
          cmd.row       = 4'($urandom_range(0, 15));
          issue(cmd, pick_gap(no_idle));
        end
      end
    end
    start <= 1'b0;

    // drain, then allow for a trailing clearing sweep
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (ROWS * COLS + 2 * COLS) @(posedge clk);

    $display("run covered %0d fingerprint bytes and %0d row reads", byte_feeds, row_reads);
    $display("%0d cell beats compared, %0d mismatches", cells_checked, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
